>>> sv/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define MSRM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// check on every clock edge, reset included
`define MSRM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

>>> sv/msrm_pkg.sv
// Shared constants, types and functions of the masked SSD RMS metric
package msrm_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int VOXEL_BITS  = 21;
   localparam int METRIC_BITS = 44;
   localparam int ACC_BITS    = 64;
   localparam int TERM_BITS   = 40;
   localparam int ROOT_BITS   = 48;
   localparam int QUO_BITS    = 96;
   localparam int PADDR_BITS  = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int DIGIT_BITS  = 16;
   localparam int DIV_SHIFT   = 31;

   localparam logic [VOXEL_BITS-1:0]  MAX_VOXELS  = 21'd1048576;
   localparam logic [METRIC_BITS-1:0] METRIC_MAX  = '1;
   localparam logic [7:0]             FULL_WEIGHT = 8'd255;
   localparam logic [7:0]             DIV_CONST   = 8'd255;
   // ceil(2^DIV_SHIFT / 255): exact quotient for every 24-bit partial dividend
   localparam logic [23:0]            DIV_RECIP   = 24'd8421505;

   localparam logic REG_VOXEL_COUNT = 1'b0;
   localparam logic REG_MASK_ENABLE = 1'b1;

   typedef struct packed {
      logic [ACC_BITS-1:0] acc;
      logic                sat;
   } msrm_img_type;

   function automatic logic signed [16:0] sample_ext(input logic [15:0] raw);
      sample_ext = $signed({{(17-SAMPLE_BITS){raw[SAMPLE_BITS-1]}}, raw[SAMPLE_BITS-1:0]});
   endfunction

endpackage

>>> sv/msrm_if.sv
// Request and response channel interfaces
interface msrm_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] target_sample;
   logic signed [15:0] source_sample;
   logic [7:0]         mask_weight;
   logic               last_element;

   modport source (output valid, target_sample, source_sample, mask_weight, last_element,
                   input ready);
   modport sink (input valid, target_sample, source_sample, mask_weight, last_element,
                 output ready);
endinterface

interface msrm_rsp_if;
   logic        valid;
   logic        ready;
   logic [43:0] metric_value;
   logic        overflow_flag;

   modport source (output valid, metric_value, overflow_flag, input ready);
   modport sink (input valid, metric_value, overflow_flag, output ready);
endinterface

>>> sv/masked_ssd_rms_metric.sv
// Masked SSD RMS metric: top level with register port and assertions
//
// req_bus carries one sample pair per transfer (target, source, mask weight,
// last flag); rsp_bus returns one metric per image, sent after the transfer
// marked last. The accumulated sum becomes floor(65536*sqrt(sum/255)/count)
// with an overflow flag telling whether the 64-bit sum saturated.
// Throughput: one sample transfer per cycle while req_bus.ready is high. The
// front end is a three-stage multiply pipeline feeding the accumulator; a
// two-entry queue hands each finished image sum to the back end.
// After the transfer marked last, the sum goes through the pipeline, the
// queue, division by 255 sixteen bits at a time, square root and division
// by the voxel count before rsp_bus.valid rises.
// The back end takes a new image sum only when idle; images arriving sooner
// fill the queue and req_bus.ready then drops until the back end takes one.
// A stalled rsp_bus holds the result in its output register; the back end
// finishes the next image and waits behind it.
// Reset clears the accumulator, queue and output; voxel_count resets to 1
// and mask_enable to 0 (weight 255). Write registers only when idle.
`include "assert_macros.svh"

module masked_ssd_rms_metric (
   input  logic                           clock,
   input  logic                           reset,
   msrm_req_if.sink                       req_bus,
   msrm_rsp_if.source                     rsp_bus,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [msrm_pkg::PADDR_BITS-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import msrm_pkg::*;

   logic [VOXEL_BITS-1:0] voxel_count_ff;
   logic                  mask_enable_ff;
   logic                  csr_wr;
   logic                  count_wr;
   logic [VOXEL_BITS-1:0] count_wdata;
   msrm_img_type          push_img, head_img;
   logic                  q_push, q_full, q_avail, q_pop;

   assign pready      = 1'b1;
   assign csr_wr      = psel && penable && pwrite;
   assign count_wr    = csr_wr && (paddr[2] == REG_VOXEL_COUNT);
   assign count_wdata = pwdata[VOXEL_BITS-1:0];
   assign prdata = (paddr[2] == REG_MASK_ENABLE) ? {31'd0, mask_enable_ff} :
                   {{(32-VOXEL_BITS){1'b0}}, voxel_count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         voxel_count_ff <= VOXEL_BITS'(1);
         mask_enable_ff <= 1'b0;
      end else if (csr_wr) begin
         if (paddr[2] == REG_VOXEL_COUNT) begin
            voxel_count_ff <= count_wdata;
         end else begin
            mask_enable_ff <= pwdata[0];
         end
      end
   end

   msrm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .mask_enable (mask_enable_ff),
      .img         (push_img),
      .img_push    (q_push),
      .q_full      (q_full)
   );

   msrm_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_data (push_img),
      .push    (q_push),
      .full    (q_full),
      .rd_data (head_img),
      .avail   (q_avail),
      .pop     (q_pop)
   );

   msrm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .img         (head_img),
      .img_avail   (q_avail),
      .img_pop     (q_pop),
      .voxel_count (voxel_count_ff),
      .rsp         (rsp_bus)
   );

   `MSRM_ASSERT(a_no_push_when_full, q_push |-> !q_full, "push into full queue")
   `MSRM_ASSERT(a_no_pop_when_empty, q_pop |-> q_avail, "pop from empty queue")
   `MSRM_ASSERT(a_count_write, count_wr |=> voxel_count_ff == $past(count_wdata), "lost write")
   `MSRM_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_bus.valid, "response valid after reset")

endmodule

>>> sv/msrm_front.sv
// Front end: squared weighted difference pipeline and 64-bit saturating accumulator
module msrm_front (
   input  logic                  clock,
   input  logic                  reset,
   msrm_req_if.sink              req,
   input  logic                  mask_enable,
   output msrm_pkg::msrm_img_type img,
   output logic                  img_push,
   input  logic                  q_full
);
   import msrm_pkg::*;

   logic                  p1_v_ff, p2_v_ff, p3_v_ff;
   logic                  p1_last_ff, p2_last_ff, p3_last_ff;
   logic [15:0]           p1_ad_ff;
   logic [7:0]            p1_w_ff, p2_w_ff;
   logic [31:0]           p2_sq_ff;
   logic [TERM_BITS-1:0]  p3_term_ff;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic                  sat_ff, sat_in;

   logic                  advance;
   logic signed [16:0]    diff;
   logic [16:0]           diff_abs;
   logic [7:0]            w_sel;
   logic [31:0]           sq;
   logic [TERM_BITS-1:0]  term;
   logic [ACC_BITS:0]     sum;
   logic [ACC_BITS-1:0]   acc_sum;
   logic                  sat_sum;

   assign advance   = !(p3_v_ff && p3_last_ff && q_full);
   assign req.ready = advance;

   assign diff     = sample_ext(req.target_sample) - sample_ext(req.source_sample);
   assign diff_abs = diff[16] ? (~diff + 17'd1) : diff;
   assign w_sel    = mask_enable ? req.mask_weight : FULL_WEIGHT;
   assign sq       = p1_ad_ff * p1_ad_ff;
   assign term     = p2_sq_ff * p2_w_ff;

   assign sum     = {1'b0, acc_ff} + {{(ACC_BITS+1-TERM_BITS){1'b0}}, p3_term_ff};
   assign acc_sum = sum[ACC_BITS] ? '1 : sum[ACC_BITS-1:0];
   assign sat_sum = sat_ff | sum[ACC_BITS];

   assign img.acc  = acc_sum;
   assign img.sat  = sat_sum;
   assign img_push = advance && p3_v_ff && p3_last_ff;

   always_comb begin
      acc_in = acc_ff;
      sat_in = sat_ff;
      if (advance && p3_v_ff) begin
         acc_in = p3_last_ff ? '0 : acc_sum;
         sat_in = p3_last_ff ? 1'b0 : sat_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         acc_ff  <= '0;
         sat_ff  <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         sat_ff <= sat_in;
         if (advance) begin
            p1_v_ff <= req.valid;
            p2_v_ff <= p1_v_ff;
            p3_v_ff <= p2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_ad_ff   <= diff_abs[15:0];
         p1_w_ff    <= w_sel;
         p1_last_ff <= req.last_element;
         p2_sq_ff   <= sq;
         p2_w_ff    <= p1_w_ff;
         p2_last_ff <= p1_last_ff;
         p3_term_ff <= term;
         p3_last_ff <= p2_last_ff;
      end
   end

endmodule

>>> sv/msrm_fifo.sv
// Two-entry queue of finished image sums between front and back end
module msrm_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  msrm_pkg::msrm_img_type wr_data,
   input  logic                  push,
   output logic                  full,
   output msrm_pkg::msrm_img_type rd_data,
   output logic                  avail,
   input  logic                  pop
);
   import msrm_pkg::*;

   msrm_img_type mem_ff [QUEUE_DEPTH];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff, count_in;

   assign full    = (count_ff == 2'(QUEUE_DEPTH));
   assign avail   = (count_ff != 2'd0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> sv/msrm_back.sv
// Back end: divide by 255, integer square root, divide by voxel count
module msrm_back (
   input  logic                           clock,
   input  logic                           reset,
   input  msrm_pkg::msrm_img_type         img,
   input  logic                           img_avail,
   output logic                           img_pop,
   input  logic [msrm_pkg::VOXEL_BITS-1:0] voxel_count,
   msrm_rsp_if.source                     rsp
);
   import msrm_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_SQRT = 3'd2;
   localparam logic [2:0] ST_DIVN = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [6:0]             cnt_ff, cnt_in;
   logic [QUO_BITS-1:0]    quo_ff, quo_in;
   logic [7:0]             rem_ff, rem_in;
   logic [49:0]            srem_ff, srem_in;
   logic [ROOT_BITS-1:0]   root_ff, root_in;
   logic [VOXEL_BITS-1:0]  nrem_ff, nrem_in;
   logic                   sat_ff, sat_in;
   logic                   rsp_v_ff, rsp_v_in;
   logic [METRIC_BITS-1:0] rsp_metric_ff;
   logic                   rsp_ovf_ff;

   logic [23:0]            div_cur, div_diff;
   logic [47:0]            div_prod;
   logic [DIGIT_BITS-1:0]  div_q;
   logic [51:0]            sq_cur, sq_trial, sq_diff;
   logic                   sq_ge;
   logic                   n_zero;
   logic [VOXEL_BITS-1:0]  n_eff;
   logic [VOXEL_BITS:0]    dn_cur, dn_diff;
   logic                   dn_ge;
   logic                   out_free, load_out;
   logic [METRIC_BITS-1:0] metric;

   assign div_cur  = {rem_ff, quo_ff[QUO_BITS-1 -: DIGIT_BITS]};
   assign div_prod = div_cur * DIV_RECIP;
   assign div_q    = div_prod[DIV_SHIFT +: DIGIT_BITS];
   assign div_diff = div_cur - {div_q, 8'd0} + {8'd0, div_q};

   assign sq_cur   = {srem_ff, quo_ff[QUO_BITS-1:QUO_BITS-2]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign sq_ge    = sq_cur >= sq_trial;
   assign sq_diff  = sq_cur - sq_trial;

   assign n_zero  = (voxel_count == '0);
   assign n_eff   = (voxel_count > MAX_VOXELS) ? MAX_VOXELS : voxel_count;
   assign dn_cur  = {nrem_ff, root_ff[ROOT_BITS-1]};
   assign dn_ge   = dn_cur >= {1'b0, n_eff};
   assign dn_diff = dn_cur - {1'b0, n_eff};

   assign out_free = !rsp_v_ff || rsp.ready;
   assign load_out = (state_ff == ST_DONE) && out_free;
   assign metric   = (n_zero || (root_ff[ROOT_BITS-1:METRIC_BITS] != '0)) ?
                     METRIC_MAX : root_ff[METRIC_BITS-1:0];
   assign img_pop  = (state_ff == ST_IDLE) && img_avail;

   assign rsp.valid         = rsp_v_ff;
   assign rsp.metric_value  = rsp_metric_ff;
   assign rsp.overflow_flag = rsp_ovf_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      nrem_in  = nrem_ff;
      sat_in   = sat_ff;
      rsp_v_in = load_out ? 1'b1 : (rsp_v_ff && !rsp.ready);
      case (state_ff)
         ST_IDLE: begin
            if (img_avail) begin
               quo_in   = {img.acc, 32'd0};
               rem_in   = '0;
               sat_in   = img.sat;
               cnt_in   = 7'(QUO_BITS / DIGIT_BITS - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = div_diff[7:0];
            quo_in = {quo_ff[QUO_BITS-DIGIT_BITS-1:0], div_q};
            if (cnt_ff == '0) begin
               srem_in  = '0;
               root_in  = '0;
               cnt_in   = 7'(ROOT_BITS - 1);
               state_in = ST_SQRT;
            end else begin
               cnt_in = cnt_ff - 7'd1;
            end
         end
         ST_SQRT: begin
            srem_in = sq_ge ? sq_diff[49:0] : sq_cur[49:0];
            root_in = {root_ff[ROOT_BITS-2:0], sq_ge};
            quo_in  = {quo_ff[QUO_BITS-3:0], 2'b00};
            if (cnt_ff == '0) begin
               nrem_in  = '0;
               cnt_in   = 7'(ROOT_BITS - 1);
               state_in = ST_DIVN;
            end else begin
               cnt_in = cnt_ff - 7'd1;
            end
         end
         ST_DIVN: begin
            nrem_in = dn_ge ? dn_diff[VOXEL_BITS-1:0] : dn_cur[VOXEL_BITS-1:0];
            root_in = {root_ff[ROOT_BITS-2:0], dn_ge};
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - 7'd1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      nrem_ff <= nrem_in;
      sat_ff  <= sat_in;
      if (load_out) begin
         rsp_metric_ff <= metric;
         rsp_ovf_ff    <= sat_ff;
      end
   end

endmodule
